// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the frame receive parser.
// Assumes clk_i and rst_ni are in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/furp_pkg.sv =====
// Types, constants and the CRC-16 byte update for the frame receive parser.
// No dependencies.
`default_nettype none

package furp_pkg;

  localparam int unsigned PayloadMaxDefault = 32;

  localparam logic [7:0]  SyncFirst = 8'hAA;
  localparam logic [7:0]  SyncSecond = 8'h55;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [8:0] {
    PH_SYNC1 = 9'b000000001,
    PH_SYNC2 = 9'b000000010,
    PH_VER   = 9'b000000100,
    PH_TYPE  = 9'b000001000,
    PH_SEQ   = 9'b000010000,
    PH_LEN   = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRCLO = 9'b010000000,
    PH_CRCHI = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FRAME_OK = 2'd1,
    EV_CRC_BAD  = 2'd2,
    EV_LEN_BAD  = 2'd3
  } event_e;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/framed_uart_receive_parser_crc16.sv =====
// Sync-headed serial frame receive parser with CRC-16/CCITT-FALSE check.
// Depends on furp_pkg and assert_macros.svh.
//
// Usage: one received byte enters per item on the input channel (in_valid_i,
// in_ready_o, rx_byte_i). Every byte gives exactly one result item on the
// output channel (out_valid_o, out_ready_i): event code, payload byte with
// its index when the byte is payload, the held header fields of the current
// frame and two wrapping 16-bit error counters.
// Path: an accepted byte is held in the input register, then parsed into the
// state and result registers, from which it is offered as a result.
// Throughput: one item per cycle while results are taken; the parse step is a
// single-byte CRC update and phase transition between the two registers.
// Reset: the hunt for 0xAA restarts, CRC goes to 0xFFFF, held fields and
// counters clear, both registers empty.
// Stall: while a result waits for out_ready_i, one more item is taken into
// the input register, then in_ready_o drops until the result leaves.
// Payload bytes are delivered as they arrive; the consumer keeps them only
// if the frame-accepted event follows.
`default_nettype none

`include "assert_macros.svh"

module framed_uart_receive_parser_crc16 #(
  parameter int unsigned PAYLOAD_MAX = furp_pkg::PayloadMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic [4:0]       payload_index_o,
  output logic [7:0]       frame_version_o,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       frame_seq_o,
  output logic [5:0]       frame_length_o,
  output logic [15:0]      crc_errors_o,
  output logic [15:0]      length_errors_o
);
  import furp_pkg::*;

  localparam logic [7:0] LenLimit = 8'(PAYLOAD_MAX);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        adv;

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  pos_inc;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  seq_q, seq_d;
  logic [5:0]  len_q, len_d;
  logic [15:0] crc_err_q, crc_err_d;
  logic [15:0] len_err_q, len_err_d;

  logic        out_vld_q;
  event_e      ev_q, ev_d;
  logic        pv_q, pv_d;
  logic [7:0]  pb_q, pb_d;
  logic [4:0]  pi_q, pi_d;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign crc_next = crc_fold(crc_q, in_byte_q);
  assign pos_inc  = pos_q + 6'd1;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    ver_d     = ver_q;
    type_d    = type_q;
    seq_d     = seq_q;
    len_d     = len_q;
    crc_err_d = crc_err_q;
    len_err_d = len_err_q;
    ev_d      = EV_NONE;
    pv_d      = 1'b0;
    pb_d      = 8'h00;
    pi_d      = 5'd0;
    unique case (phase_q)
      PH_SYNC1: begin
        if (in_byte_q == SyncFirst) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (in_byte_q == SyncSecond) begin
          phase_d = PH_VER;
          crc_d   = CrcInit;
        end else if (in_byte_q != SyncFirst) begin
          phase_d = PH_SYNC1;
        end
      end
      PH_VER: begin
        ver_d   = in_byte_q;
        crc_d   = crc_next;
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        type_d  = in_byte_q;
        crc_d   = crc_next;
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d   = in_byte_q;
        crc_d   = crc_next;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = in_byte_q[5:0];
        pos_d = 6'd0;
        crc_d = crc_next;
        if (in_byte_q > LenLimit) begin
          len_err_d = len_err_q + 16'd1;
          ev_d      = EV_LEN_BAD;
          phase_d   = PH_SYNC1;
        end else begin
          phase_d = (in_byte_q[5:0] != 6'd0) ? PH_DATA : PH_CRCLO;
        end
      end
      PH_DATA: begin
        pv_d  = 1'b1;
        pb_d  = in_byte_q;
        pi_d  = pos_q[4:0];
        crc_d = crc_next;
        pos_d = pos_inc;
        if (pos_inc >= len_q) phase_d = PH_CRCLO;
      end
      PH_CRCLO: begin
        crc_lo_d = in_byte_q;
        phase_d  = PH_CRCHI;
      end
      PH_CRCHI: begin
        phase_d = PH_SYNC1;
        if ({in_byte_q, crc_lo_q} == crc_q) begin
          ev_d = EV_FRAME_OK;
        end else begin
          crc_err_d = crc_err_q + 16'd1;
          ev_d      = EV_CRC_BAD;
        end
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      pos_q     <= 6'd0;
      crc_q     <= CrcInit;
      crc_lo_q  <= 8'h00;
      ver_q     <= 8'h00;
      type_q    <= 8'h00;
      seq_q     <= 8'h00;
      len_q     <= 6'd0;
      crc_err_q <= 16'd0;
      len_err_q <= 16'd0;
    end else if (adv) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      crc_lo_q  <= crc_lo_d;
      ver_q     <= ver_d;
      type_q    <= type_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      crc_err_q <= crc_err_d;
      len_err_q <= len_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ev_q <= ev_d;
      pv_q <= pv_d;
      pb_q <= pb_d;
      pi_q <= pi_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = ev_q;
  assign payload_valid_o = pv_q;
  assign payload_byte_o  = pb_q;
  assign payload_index_o = pi_q;
  assign frame_version_o = ver_q;
  assign frame_type_o    = type_q;
  assign frame_seq_o     = seq_q;
  assign frame_length_o  = len_q;
  assign crc_errors_o    = crc_err_q;
  assign length_errors_o = len_err_q;

  `ASSERT_NEXT(a_crchi_gives_verdict, adv && phase_q == PH_CRCHI,
               ev_q == EV_FRAME_OK || ev_q == EV_CRC_BAD, "CRC byte without verdict")
  `ASSERT_NEXT(a_crc_err_count, adv && phase_q == PH_CRCHI && ev_d == EV_CRC_BAD,
               crc_err_q == $past(crc_err_q) + 16'd1, "crc error count not bumped")
  `ASSERT_SAME(a_payload_no_event, out_vld_q && pv_q, ev_q == EV_NONE,
               "payload item carries an event")
  `ASSERT_NEXT(a_held_item_kept, in_vld_q && !adv, in_vld_q && $stable(in_byte_q),
               "held item lost while stalled")

endmodule

`default_nettype wire
